// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
// Every check samples on the block clock and is off while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define EFC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define EFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/efc_pkg.sv
`timescale 1ns / 1ps

package efc_pkg;

    // Highest valid floor number, floors count from 1
    localparam logic [3:0] FLOORS = 4'd7;
    // Request queue depth
    localparam int unsigned QDEPTH = 7;
    // Door open time after reset
    localparam logic [15:0] WAIT_TICKS_RESET = 16'd1000;

    // Event codes
    localparam logic [2:0] ACT_REQUEST = 3'd0;
    localparam logic [2:0] ACT_ARRIVED = 3'd1;
    localparam logic [2:0] ACT_OPENED  = 3'd2;
    localparam logic [2:0] ACT_CLOSED  = 3'd3;
    localparam logic [2:0] ACT_TICK    = 3'd4;
    localparam logic [2:0] ACT_PASSING = 3'd5;

    // Car state codes as seen on the result beat
    localparam logic [2:0] CODE_IDLE    = 3'd0;
    localparam logic [2:0] CODE_UP      = 3'd1;
    localparam logic [2:0] CODE_DOWN    = 3'd2;
    localparam logic [2:0] CODE_OPENING = 3'd3;
    localparam logic [2:0] CODE_WAITING = 3'd4;
    localparam logic [2:0] CODE_CLOSING = 3'd5;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_UP      = 6'b000010,
        ST_DOWN    = 6'b000100,
        ST_OPENING = 6'b001000,
        ST_WAITING = 6'b010000,
        ST_CLOSING = 6'b100000
    } car_state_t;

    typedef logic [2:0] floor_t;

    // Map the one-hot state to its external code
    function automatic logic [2:0] state_code(car_state_t st);
        logic [2:0] code;
        unique case (st)
            ST_IDLE:    code = CODE_IDLE;
            ST_UP:      code = CODE_UP;
            ST_DOWN:    code = CODE_DOWN;
            ST_OPENING: code = CODE_OPENING;
            ST_WAITING: code = CODE_WAITING;
            ST_CLOSING: code = CODE_CLOSING;
            default:    code = CODE_IDLE;
        endcase
        return code;
    endfunction

    // Lamp mask of one floor; floor 0 maps to no lamp
    function automatic logic [6:0] lamp_bit(floor_t f);
        return 7'd1 << (f - 3'd1);
    endfunction

    function automatic logic floor_ok(floor_t f);
        return (f != 3'd0) && ({1'b0, f} <= FLOORS);
    endfunction

endpackage

// File: rtl/core/elevator_fifo_controller_top.sv
`timescale 1ns / 1ps
// Elevator car controller with a unique first-in first-out request queue.
// Input channel (s_valid/s_ready): one event per beat, s_action selects
// request, arrived, doors opened, doors closed, tick or passing floor, and
// s_floor carries the 1-based floor for requests and passing events.
// Result channel (m_valid/m_ready): exactly one beat per event, showing the
// car state, current floor, goal floor, lit buttons, queue fill and whether
// the event was a request for an invalid floor.
// Configuration: cfg_wr_en writes cfg_wr_data into the door wait count;
// write it only while no event is in flight.
// The result beat is registered and valid in the cycle after the event is accepted.
// Throughput: one event per cycle while s_ready is high; the whole update is one
// combinational pass from the event and the state registers into the state and
// result registers.
// Stall: s_ready stays high while the result register is empty or being
// drained; when m_ready is low with a result held, s_ready drops.
// Reset (aresetn low, synchronous): car idle at floor 1, no goal, queue
// empty, all lamps off, wait count 1000, no result pending.
module elevator_fifo_controller_top
    import efc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic [2:0]  s_floor,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_car_state,
    output logic [2:0]  m_at_floor,
    output logic [2:0]  m_goal_floor,
    output logic [6:0]  m_lamps,
    output logic [2:0]  m_pending,
    output logic        m_rejected
);

    `include "assert_macros.svh"

    car_state_t  state_reg, state_next;
    floor_t      here_reg, here_next;
    floor_t      goal_reg, goal_next;
    floor_t      fifo_reg [QDEPTH];
    floor_t      fifo_next [QDEPTH];
    logic [2:0]  count_reg, count_next;
    logic [6:0]  lit_reg, lit_next;
    logic [15:0] wait_left_reg, wait_left_next;
    logic [15:0] wait_ticks_reg;
    logic        rejected_next;

    logic        m_valid_reg;
    logic [2:0]  res_state_reg;
    floor_t      res_here_reg;
    floor_t      res_goal_reg;
    logic [6:0]  res_lit_reg;
    logic [2:0]  res_count_reg;
    logic        res_rejected_reg;

    logic        s_fire;
    logic        found;
    logic        push;
    logic        pop;
    logic        moving;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign moving  = (state_reg == ST_UP) || (state_reg == ST_DOWN);

    // Look for the requested floor among the live queue entries
    always_comb begin
        found = 1'b0;
        for (int i = 0; i < QDEPTH; i++) begin
            if ((3'(i) < count_reg) && (fifo_reg[i] == s_floor)) begin
                found = 1'b1;
            end
        end
    end

    // Next state for one event
    always_comb begin
        state_next     = state_reg;
        here_next      = here_reg;
        goal_next      = goal_reg;
        count_next     = count_reg;
        lit_next       = lit_reg;
        wait_left_next = wait_left_reg;
        rejected_next  = 1'b0;
        push           = 1'b0;
        pop            = 1'b0;

        unique case (s_action)
            ACT_REQUEST: begin
                if (!floor_ok(s_floor)) begin
                    rejected_next = 1'b1;
                end else if ((state_reg == ST_IDLE || state_reg == ST_CLOSING)
                             && s_floor == here_reg) begin
                    state_next = ST_OPENING;
                end else if (state_reg == ST_IDLE) begin
                    goal_next  = s_floor;
                    lit_next   = lit_reg | lamp_bit(s_floor);
                    state_next = (s_floor > here_reg) ? ST_UP : ST_DOWN;
                end else if (s_floor != here_reg && s_floor != goal_reg) begin
                    if (found) begin
                        lit_next = lit_reg | lamp_bit(s_floor);
                    end else if (32'(count_reg) < QDEPTH) begin
                        push       = 1'b1;
                        count_next = count_reg + 3'd1;
                        lit_next   = lit_reg | lamp_bit(s_floor);
                    end
                end
            end
            ACT_ARRIVED: begin
                if ((state_reg == ST_UP || state_reg == ST_DOWN) && goal_reg != 3'd0) begin
                    here_next  = goal_reg;
                    lit_next   = lit_reg & ~lamp_bit(goal_reg);
                    goal_next  = 3'd0;
                    state_next = ST_OPENING;
                end
            end
            ACT_OPENED: begin
                if (state_reg == ST_OPENING) begin
                    state_next     = ST_WAITING;
                    wait_left_next = wait_ticks_reg;
                end
            end
            ACT_CLOSED: begin
                if (state_reg == ST_CLOSING) begin
                    if (count_reg == 3'd0) begin
                        state_next = ST_IDLE;
                    end else begin
                        pop        = 1'b1;
                        goal_next  = fifo_reg[0];
                        count_next = count_reg - 3'd1;
                        state_next = (fifo_reg[0] > here_reg) ? ST_UP : ST_DOWN;
                    end
                end
            end
            ACT_TICK: begin
                if (state_reg == ST_WAITING) begin
                    if (wait_left_reg <= 16'd1) begin
                        wait_left_next = 16'd0;
                        state_next     = ST_CLOSING;
                    end else begin
                        wait_left_next = wait_left_reg - 16'd1;
                    end
                end
            end
            ACT_PASSING: begin
                if (floor_ok(s_floor)) begin
                    here_next = s_floor;
                end
            end
            default: begin
                state_next = state_reg;
            end
        endcase
    end

    // Queue entries: append at the fill point, shift toward the head on pop
    always_comb begin
        for (int i = 0; i < QDEPTH; i++) begin
            fifo_next[i] = fifo_reg[i];
        end
        for (int i = 0; i < QDEPTH - 1; i++) begin
            if (pop) begin
                fifo_next[i] = fifo_reg[i + 1];
            end
        end
        for (int i = 0; i < QDEPTH; i++) begin
            if (push && count_reg == 3'(i)) begin
                fifo_next[i] = s_floor;
            end
        end
    end

    // Control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            here_reg       <= 3'd1;
            goal_reg       <= 3'd0;
            count_reg      <= 3'd0;
            lit_reg        <= 7'd0;
            wait_left_reg  <= 16'd0;
            wait_ticks_reg <= WAIT_TICKS_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                wait_ticks_reg <= cfg_wr_data;
            end
            if (s_fire) begin
                state_reg     <= state_next;
                here_reg      <= here_next;
                goal_reg      <= goal_next;
                count_reg     <= count_next;
                lit_reg       <= lit_next;
                wait_left_reg <= wait_left_next;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Queue storage and result beat payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            for (int i = 0; i < QDEPTH; i++) begin
                fifo_reg[i] <= fifo_next[i];
            end
            res_state_reg    <= state_code(state_next);
            res_here_reg     <= here_next;
            res_goal_reg     <= goal_next;
            res_lit_reg      <= lit_next;
            res_count_reg    <= count_next;
            res_rejected_reg <= rejected_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_car_state  = res_state_reg;
    assign m_at_floor   = res_here_reg;
    assign m_goal_floor = res_goal_reg;
    assign m_lamps      = res_lit_reg;
    assign m_pending    = res_count_reg;
    assign m_rejected   = res_rejected_reg;

    // Checks
    `EFC_ASSERT(a_goal_iff_moving, moving == (goal_reg != 3'd0), "goal without move")
    `EFC_ASSERT(a_wait_zero, state_reg == ST_WAITING || wait_left_reg == 16'd0, "wait left set")
    `EFC_ASSERT(a_queue_lamps, count_reg == 3'd0 || lit_reg != 7'd0, "queued floor without lamp")
    `EFC_ASSERT_NEXT(a_event_beat, s_fire, m_valid_reg, "no result beat")

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import efc_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int STUCK_LIMIT = 4000;

    // Car state as tracked by the predictor
    typedef struct packed {
        logic [2:0]                mode;
        floor_t                    here;
        floor_t                    goal;
        floor_t [QDEPTH-1:0]       queue;
        logic [2:0]                count;
        logic [6:0]                lit;
        logic [15:0]               wait_left;
        logic [15:0]               wait_ticks;
    } car_t;

    // One result beat
    typedef struct packed {
        logic [2:0] car_state;
        floor_t     at_floor;
        floor_t     goal_floor;
        logic [6:0] lamps;
        logic [2:0] pending;
        logic       rejected;
    } status_t;

    // One event beat
    typedef struct packed {
        logic [2:0] action;
        floor_t     floor;
    } call_t;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = 16'd0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [2:0]  s_action    = ACT_REQUEST;
    floor_t      s_floor     = 3'd0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [2:0]  m_car_state;
    logic [2:0]  m_at_floor;
    logic [2:0]  m_goal_floor;
    logic [6:0]  m_lamps;
    logic [2:0]  m_pending;
    logic        m_rejected;

    call_t   call_q[$];
    status_t status_q[$];
    car_t    model_car;
    car_t    plan_car;
    int      send_idle_pct = 0;
    int      stall_pct     = 0;
    int      hold_request  = 0;
    int      hold_seen     = 0;
    int      hold_left     = 0;
    int      stuck_cycles  = 0;
    int      errors        = 0;
    status_t got;
    status_t want;

    elevator_fifo_controller_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_floor      (s_floor),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_car_state  (m_car_state),
        .m_at_floor   (m_at_floor),
        .m_goal_floor (m_goal_floor),
        .m_lamps      (m_lamps),
        .m_pending    (m_pending),
        .m_rejected   (m_rejected)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic car_t fresh_car();
        car_t c;
        c            = '0;
        c.mode       = CODE_IDLE;
        c.here       = 3'd1;
        c.wait_ticks = WAIT_TICKS_RESET;
        return c;
    endfunction

    // Apply one event to a car and return the beat it produces
    function automatic status_t advance_car(inout car_t c, input logic [2:0] act,
                                            input floor_t f);
        status_t r;
        logic    valid_floor;
        logic    found;
        logic [6:0] lamp;
        int      i;
        r           = '0;
        valid_floor = (f != 3'd0) && ({1'b0, f} <= FLOORS);
        lamp        = 7'd1 << (f - 3'd1);
        found       = 1'b0;
        case (act)
            ACT_REQUEST: begin
                if (!valid_floor) begin
                    r.rejected = 1'b1;
                end else if ((c.mode == CODE_IDLE || c.mode == CODE_CLOSING) &&
                             f == c.here) begin
                    c.mode = CODE_OPENING;
                end else if (c.mode == CODE_IDLE) begin
                    c.goal = f;
                    c.lit  = c.lit | lamp;
                    c.mode = (c.goal > c.here) ? CODE_UP : CODE_DOWN;
                end else if (f != c.here && f != c.goal) begin
                    for (i = 0; i < QDEPTH; i++)
                        if (i < c.count && c.queue[i] == f)
                            found = 1'b1;
                    // drop on overflow without lighting the button
                    if (found || c.count < QDEPTH) begin
                        if (!found) begin
                            c.queue[c.count] = f;
                            c.count          = c.count + 3'd1;
                        end
                        c.lit = c.lit | lamp;
                    end
                end
            end
            ACT_ARRIVED: begin
                if ((c.mode == CODE_UP || c.mode == CODE_DOWN) && c.goal != 3'd0) begin
                    c.here = c.goal;
                    c.lit  = c.lit & ~(7'd1 << (c.goal - 3'd1));
                    c.goal = 3'd0;
                    c.mode = CODE_OPENING;
                end
            end
            ACT_OPENED: begin
                if (c.mode == CODE_OPENING) begin
                    c.mode      = CODE_WAITING;
                    c.wait_left = c.wait_ticks;
                end
            end
            ACT_CLOSED: begin
                if (c.mode == CODE_CLOSING) begin
                    if (c.count == 3'd0) begin
                        c.mode = CODE_IDLE;
                    end else begin
                        // pop the head and shift the rest down
                        c.goal = c.queue[0];
                        for (i = 0; i < QDEPTH - 1; i++)
                            c.queue[i] = c.queue[i+1];
                        c.queue[QDEPTH-1] = 3'd0;
                        c.count = c.count - 3'd1;
                        c.mode  = (c.goal > c.here) ? CODE_UP : CODE_DOWN;
                    end
                end
            end
            ACT_TICK: begin
                if (c.mode == CODE_WAITING) begin
                    if (c.wait_left <= 16'd1) begin
                        c.wait_left = 16'd0;
                        c.mode      = CODE_CLOSING;
                    end else begin
                        c.wait_left = c.wait_left - 16'd1;
                    end
                end
            end
            ACT_PASSING: begin
                if (valid_floor)
                    c.here = f;
            end
            default: ;
        endcase
        r.car_state  = c.mode;
        r.at_floor   = c.here;
        r.goal_floor = c.goal;
        r.lamps      = c.lit;
        r.pending    = c.count;
        return r;
    endfunction

    // Queue one event and track its effect on the planning copy
    task automatic queue_call(input logic [2:0] act, input floor_t f);
        status_t unused;
        call_t   item;
        item.action = act;
        item.floor  = f;
        unused      = advance_car(plan_car, act, f);
        call_q.push_back(item);
    endtask

    // Mostly the event the car is waiting for, with some noise
    task automatic queue_journeys(input int n);
        int     k;
        int     roll;
        floor_t any_floor;
        for (k = 0; k < n; k++) begin
            roll      = $urandom_range(99);
            any_floor = floor_t'($urandom_range(1, 7));
            if (roll < 12) begin
                queue_call(3'($urandom_range(7)), floor_t'($urandom_range(7)));
            end else begin
                roll = $urandom_range(99);
                case (plan_car.mode)
                    CODE_IDLE: queue_call(ACT_REQUEST, any_floor);
                    CODE_UP, CODE_DOWN: begin
                        if (roll < 20)
                            queue_call(ACT_REQUEST, any_floor);
                        else if (roll < 35)
                            queue_call(ACT_PASSING, any_floor);
                        else
                            queue_call(ACT_ARRIVED, any_floor);
                    end
                    CODE_OPENING: begin
                        if (roll < 20)
                            queue_call(ACT_REQUEST, any_floor);
                        else
                            queue_call(ACT_OPENED, any_floor);
                    end
                    CODE_WAITING: begin
                        if (roll < 25)
                            queue_call(ACT_REQUEST, any_floor);
                        else
                            queue_call(ACT_TICK, any_floor);
                    end
                    default: begin
                        if (roll < 15)
                            queue_call(ACT_REQUEST, plan_car.here);
                        else if (roll < 30)
                            queue_call(ACT_REQUEST, any_floor);
                        else
                            queue_call(ACT_CLOSED, any_floor);
                    end
                endcase
            end
        end
    endtask

    // Wait until every event is in and every beat is out, then let the block settle
    task automatic settle();
        while (call_q.size() != 0 || s_valid || status_q.size() != 0 || m_valid)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_wait_ticks(input logic [15:0] value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        model_car.wait_ticks = value;
        plan_car.wait_ticks  = value;
    endtask

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d",
                     $time, name, exp_val, act_val);
        end
    endtask

    // Drive event beats and predict each accepted one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                status_q.push_back(advance_car(model_car, s_action, s_floor));
            if (!s_valid || s_ready) begin
                if (call_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid  <= 1'b1;
                    s_action <= call_q[0].action;
                    s_floor  <= call_q[0].floor;
                    void'(call_q.pop_front());
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Check result beats and throttle the result channel
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_car_state, m_at_floor, m_goal_floor, m_lamps, m_pending,
                       m_rejected};
                if (status_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result beat, expected none actual %h",
                             $time, got);
                end else begin
                    want = status_q.pop_front();
                    check_field("car_state", want.car_state, got.car_state);
                    check_field("at_floor", want.at_floor, got.at_floor);
                    check_field("goal_floor", want.goal_floor, got.goal_floor);
                    check_field("lamps", want.lamps, got.lamps);
                    check_field("pending", want.pending, got.pending);
                    check_field("rejected", want.rejected, got.rejected);
                end
            end
            // long hold-off on request, else random stalls
            if (hold_seen != hold_request) begin
                hold_seen <= hold_request;
                hold_left <= HOLD_CYCLES;
                m_ready   <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Abort when no beat moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        model_car = fresh_car();
        plan_car  = fresh_car();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // idle car: wrong-mode events, unused actions, invalid floors, a pass and a current-floor request
        queue_call(ACT_TICK, 3'd0);
        queue_call(ACT_OPENED, 3'd7);
        queue_call(ACT_CLOSED, 3'd2);
        queue_call(ACT_ARRIVED, 3'd4);
        queue_call(3'd6, 3'd5);
        queue_call(3'd7, 3'd7);
        queue_call(ACT_REQUEST, 3'd0);
        queue_call(ACT_PASSING, 3'd0);
        queue_call(ACT_PASSING, 3'd3);
        queue_call(ACT_REQUEST, 3'd3);

        // zero wait, dedup, reopen, goal and current-floor requests, pop onto here
        set_wait_ticks(16'd0);
        queue_call(ACT_OPENED, 3'd0);
        queue_call(ACT_REQUEST, 3'd3);
        queue_call(ACT_REQUEST, 3'd5);
        queue_call(ACT_REQUEST, 3'd5);
        queue_call(ACT_TICK, 3'd0);
        queue_call(ACT_REQUEST, 3'd3);
        queue_call(ACT_OPENED, 3'd0);
        queue_call(ACT_REQUEST, 3'd6);
        queue_call(ACT_REQUEST, 3'd1);
        queue_call(ACT_TICK, 3'd0);
        queue_call(ACT_CLOSED, 3'd0);
        queue_call(ACT_REQUEST, 3'd5);
        queue_call(ACT_PASSING, 3'd4);
        queue_call(ACT_REQUEST, 3'd4);
        queue_call(ACT_REQUEST, 3'd7);
        queue_call(ACT_ARRIVED, 3'd0);
        queue_call(ACT_OPENED, 3'd0);
        queue_call(ACT_PASSING, 3'd6);
        queue_call(ACT_TICK, 3'd0);
        queue_call(ACT_CLOSED, 3'd0);
        queue_call(ACT_ARRIVED, 3'd0);
        queue_call(ACT_OPENED, 3'd0);
        queue_call(ACT_TICK, 3'd0);
        queue_call(ACT_CLOSED, 3'd0);

        // no idling, with one long receiver hold-off
        set_wait_ticks(16'd1);
        send_idle_pct = 0;
        stall_pct     = 0;
        queue_journeys(250);
        hold_request++;

        set_wait_ticks(16'd3);
        send_idle_pct = 53;
        stall_pct     = 0;
        queue_journeys(250);

        set_wait_ticks(16'd2);
        send_idle_pct = 0;
        stall_pct     = 53;
        queue_journeys(250);

        set_wait_ticks(16'($urandom_range(4, 9)));
        send_idle_pct = 7;
        stall_pct     = 7;
        queue_journeys(250);

        set_wait_ticks(16'd1);
        send_idle_pct = 0;
        stall_pct     = 0;
        queue_journeys(100);

        // longest wait last, so a door wait started after this does not run out
        set_wait_ticks(16'hFFFF);
        queue_journeys(40);

        settle();
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
